// ===== sv/wsp_pkg.sv =====
// shared types and constants for the wave header and sample parser
package wsp_pkg;

  localparam logic [31:0] TAG_RIFF  = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE  = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT   = 32'h2074_6D66;
  localparam logic [31:0] SIZE_BIAS = 32'd36;
  localparam logic [7:0]  CHAR_D    = 8'h64;
  localparam logic [7:0]  CHAR_T    = 8'h74;
  localparam logic [7:0]  CHAR_A    = 8'h61;
  localparam logic [31:0] RECIP3    = 32'hAAAA_AAAB;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_NOT_RIFF = 3'd1;
  localparam logic [2:0] ERR_NOT_WAVE = 3'd2;
  localparam logic [2:0] ERR_NO_FMT   = 3'd3;
  localparam logic [2:0] ERR_FORMAT   = 3'd4;
  localparam logic [2:0] ERR_NO_DATA  = 3'd5;

  typedef struct packed {
    logic       shift_en;
    logic       ld_riff;
    logic       ld_chan;
    logic       ld_rate;
    logic       ld_depth;
    logic       scan_clr;
    logic       scan_inc;
    logic       ld_pair;
    logic       emit_hdr;
    logic       emit_smp;
    logic       emit_err;
    logic [2:0] err_code;
  } wsp_cmd_t;

  typedef struct packed {
    logic       riff_ok;
    logic       wave_ok;
    logic       fmt_ok;
    logic       pcm_ok;
    logic       depth_ok;
    logic       pair_da;
    logic       pair_ta;
    logic       scan_odd;
    logic       scan_end;
    logic [1:0] nm1;
  } wsp_sts_t;

endpackage

// ===== sv/wsp_ctrl.sv =====
// parse controller: phase sequencing and command generation
module wsp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  wsp_pkg::wsp_sts_t sts_i,
  output wsp_pkg::wsp_cmd_t cmd_o
);
  import wsp_pkg::*;

  typedef enum logic [2:0] {
    PH_RIFF, PH_SIZE, PH_WAVE, PH_FMT, PH_SCAN, PH_DSIZE, PH_SAMP, PH_ERR
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [5:0] off_q, off_d;
  logic [1:0] sbc_q, sbc_d;
  logic       da_q, da_d;

  always_comb begin
    phase_d = phase_q;
    off_d   = off_q;
    sbc_d   = sbc_q;
    da_d    = da_q;
    cmd_o   = '0;
    if (accept_i && phase_q != PH_ERR) begin
      cmd_o.shift_en = 1'b1;
      unique case (phase_q)
        PH_RIFF, PH_SIZE, PH_WAVE, PH_FMT: begin
          off_d = off_q + 6'd1;
          case (off_q)
            6'd3: begin
              if (!sts_i.riff_ok) begin
                cmd_o.emit_err = 1'b1;
                cmd_o.err_code = ERR_NOT_RIFF;
                phase_d = PH_ERR;
              end else begin
                phase_d = PH_SIZE;
              end
            end
            6'd7: begin
              cmd_o.ld_riff = 1'b1;
              phase_d = PH_WAVE;
            end
            6'd11: begin
              if (!sts_i.wave_ok) begin
                cmd_o.emit_err = 1'b1;
                cmd_o.err_code = ERR_NOT_WAVE;
                phase_d = PH_ERR;
              end else begin
                phase_d = PH_FMT;
              end
            end
            6'd15: begin
              if (!sts_i.fmt_ok) begin
                cmd_o.emit_err = 1'b1;
                cmd_o.err_code = ERR_NO_FMT;
                phase_d = PH_ERR;
              end
            end
            6'd21: begin
              if (!sts_i.pcm_ok) begin
                cmd_o.emit_err = 1'b1;
                cmd_o.err_code = ERR_FORMAT;
                phase_d = PH_ERR;
              end
            end
            6'd23: cmd_o.ld_chan = 1'b1;
            6'd27: cmd_o.ld_rate = 1'b1;
            6'd35: begin
              cmd_o.ld_depth = 1'b1;
              if (!sts_i.depth_ok) begin
                cmd_o.emit_err = 1'b1;
                cmd_o.err_code = ERR_FORMAT;
                phase_d = PH_ERR;
              end else begin
                cmd_o.scan_clr = 1'b1;
                da_d = 1'b0;
                phase_d = PH_SCAN;
              end
            end
            default: ;
          endcase
        end
        PH_SCAN: begin
          cmd_o.scan_inc = 1'b1;
          if (!sts_i.scan_odd) begin
            cmd_o.ld_pair = 1'b1;
          end else if (da_q) begin
            da_d = 1'b0;
            if (sts_i.pair_ta) begin
              phase_d = PH_DSIZE;
              sbc_d = 2'd0;
            end else if (sts_i.scan_end) begin
              cmd_o.emit_err = 1'b1;
              cmd_o.err_code = ERR_NO_DATA;
              phase_d = PH_ERR;
            end
          end else if (sts_i.pair_da) begin
            da_d = 1'b1;
          end else if (sts_i.scan_end) begin
            cmd_o.emit_err = 1'b1;
            cmd_o.err_code = ERR_NO_DATA;
            phase_d = PH_ERR;
          end
        end
        PH_DSIZE: begin
          if (sbc_q != 2'd3) begin
            sbc_d = sbc_q + 2'd1;
          end else begin
            sbc_d = 2'd0;
            cmd_o.emit_hdr = 1'b1;
            phase_d = PH_SAMP;
          end
        end
        PH_SAMP: begin
          if (sbc_q < sts_i.nm1) begin
            sbc_d = sbc_q + 2'd1;
          end else begin
            sbc_d = 2'd0;
            cmd_o.emit_smp = 1'b1;
          end
        end
        PH_ERR: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      off_q   <= '0;
      sbc_q   <= '0;
      da_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      off_q   <= off_d;
      sbc_q   <= sbc_d;
      da_q    <= da_d;
    end
  end

endmodule

// ===== sv/wsp_dpath.sv =====
// parse datapath: field capture, scan counter, sample assembly, result register
module wsp_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        data_byte_i,
  input  logic              mid_side_i,
  input  wsp_pkg::wsp_cmd_t cmd_i,
  output wsp_pkg::wsp_sts_t sts_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [1:0]        result_kind_o,
  output logic [2:0]        error_code_o,
  output logic [15:0]       channel_count_o,
  output logic [31:0]       sample_rate_o,
  output logic [15:0]       bits_per_sample_o,
  output logic [31:0]       sample_total_o,
  output logic [15:0]       channel_index_o,
  output logic signed [31:0] sample_value_o
);
  import wsp_pkg::*;

  function automatic logic [31:0] sext_w(input logic [31:0] v, input logic [1:0] nm1);
    logic [31:0] r;
    case (nm1)
      2'd0:    r = {{24{v[7]}}, v[7:0]};
      2'd1:    r = {{16{v[15]}}, v[15:0]};
      2'd2:    r = {{8{v[23]}}, v[23:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  logic [31:0] fs_q, fs_d;
  logic [31:0] riff_q, rate_q, scan_q;
  logic [15:0] chan_q, depth_q, cur_q;
  logic [7:0]  pair_q;
  logic [31:0] left_q;
  logic        valid_q;
  logic [1:0]  kind_q;
  logic [2:0]  err_q;
  logic [15:0] ocnt_q, obits_q, ochan_q;
  logic [31:0] orate_q, ototal_q, oval_q;

  logic [1:0]  nm1;
  logic [15:0] hi16;
  logic [31:0] aligned, value, side, total;
  logic [63:0] prod;
  logic [16:0] cur_inc;

  assign fs_d = {data_byte_i, fs_q[31:8]};
  assign hi16 = fs_d[31:16];
  assign nm1  = depth_q[4:3] - 2'd1;

  assign sts_o.riff_ok  = (fs_d == TAG_RIFF);
  assign sts_o.wave_ok  = (fs_d == TAG_WAVE);
  assign sts_o.fmt_ok   = (fs_d == TAG_FMT);
  assign sts_o.pcm_ok   = (hi16 == 16'd1);
  assign sts_o.depth_ok = (hi16 == 16'd8) || (hi16 == 16'd16) ||
                          (hi16 == 16'd24) || (hi16 == 16'd32);
  assign sts_o.pair_da  = (pair_q == CHAR_D) && (data_byte_i == CHAR_A);
  assign sts_o.pair_ta  = (pair_q == CHAR_T) && (data_byte_i == CHAR_A);
  assign sts_o.scan_odd = scan_q[0];
  assign sts_o.scan_end = (scan_q + 32'd1) >= riff_q;
  assign sts_o.nm1      = nm1;

  // division of the data size by bytes per sample
  assign prod = 64'(fs_d) * 64'(RECIP3);
  always_comb begin
    case (nm1)
      2'd0:    total = fs_d;
      2'd1:    total = fs_d >> 1;
      2'd2:    total = 32'(prod[63:33]);
      default: total = fs_d >> 2;
    endcase
  end

  always_comb begin
    case (nm1)
      2'd0:    aligned = {24'd0, fs_d[31:24]};
      2'd1:    aligned = {16'd0, fs_d[31:16]};
      2'd2:    aligned = {8'd0, fs_d[31:8]};
      default: aligned = fs_d;
    endcase
  end

  assign value   = sext_w(aligned, nm1);
  assign side    = sext_w(left_q - value, nm1);
  assign cur_inc = {1'b0, cur_q} + 17'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q     <= '0;
      riff_q   <= '0;
      rate_q   <= '0;
      scan_q   <= '0;
      chan_q   <= '0;
      depth_q  <= '0;
      cur_q    <= '0;
      pair_q   <= '0;
      left_q   <= '0;
      valid_q  <= 1'b0;
      kind_q   <= '0;
      err_q    <= '0;
      ocnt_q   <= '0;
      obits_q  <= '0;
      ochan_q  <= '0;
      orate_q  <= '0;
      ototal_q <= '0;
      oval_q   <= '0;
    end else begin
      if (cmd_i.emit_hdr || cmd_i.emit_smp || cmd_i.emit_err) valid_q <= 1'b1;
      else if (valid_q && !out_stall_i) valid_q <= 1'b0;
      if (cmd_i.shift_en) fs_q <= fs_d;
      if (cmd_i.ld_riff)  riff_q <= fs_d - SIZE_BIAS;
      if (cmd_i.ld_chan)  chan_q <= hi16;
      if (cmd_i.ld_rate)  rate_q <= fs_d;
      if (cmd_i.ld_depth) depth_q <= hi16;
      if (cmd_i.scan_clr) scan_q <= '0;
      else if (cmd_i.scan_inc) scan_q <= scan_q + 32'd1;
      if (cmd_i.ld_pair)  pair_q <= data_byte_i;

      if (cmd_i.emit_err) begin
        kind_q   <= KIND_ERROR;
        err_q    <= cmd_i.err_code;
        ocnt_q   <= '0;
        orate_q  <= '0;
        obits_q  <= '0;
        ototal_q <= '0;
        ochan_q  <= '0;
        oval_q   <= '0;
      end else if (cmd_i.emit_hdr) begin
        kind_q   <= KIND_HEADER;
        err_q    <= ERR_OK;
        ocnt_q   <= chan_q;
        orate_q  <= rate_q;
        obits_q  <= depth_q;
        ototal_q <= total;
        ochan_q  <= '0;
        oval_q   <= '0;
        cur_q    <= '0;
      end else if (cmd_i.emit_smp) begin
        kind_q   <= KIND_SAMPLE;
        err_q    <= ERR_OK;
        ocnt_q   <= '0;
        orate_q  <= '0;
        obits_q  <= '0;
        ototal_q <= '0;
        if (mid_side_i) begin
          if (cur_q == 16'd0) begin
            left_q  <= value;
            ochan_q <= 16'd0;
            oval_q  <= value;
            cur_q   <= 16'd1;
          end else begin
            ochan_q <= 16'd1;
            oval_q  <= side;
            cur_q   <= '0;
          end
        end else begin
          ochan_q <= cur_q;
          oval_q  <= value;
          if (cur_inc >= {1'b0, chan_q}) cur_q <= '0;
          else cur_q <= cur_inc[15:0];
        end
      end
    end
  end

  assign out_valid_o       = valid_q;
  assign result_kind_o     = kind_q;
  assign error_code_o      = err_q;
  assign channel_count_o   = ocnt_q;
  assign sample_rate_o     = orate_q;
  assign bits_per_sample_o = obits_q;
  assign sample_total_o    = ototal_q;
  assign channel_index_o   = ochan_q;
  assign sample_value_o    = signed'(oval_q);

endmodule

// ===== sv/wav_header_and_sample_parser.sv =====
// top level of the wave header and sample parser
// Takes one stream byte per transaction and can accept a byte every cycle; each byte
// gives at most one result, so input stalls only while a finished result waits
// in the single output register with the output side stalled. The header result
// is registered in the cycle after the last data size byte is taken, through
// one 32x32 reciprocal multiply for the divide by three.
// After an error the block takes and drops every byte until reset. The
// mid_side_mode register sits at byte address 0 of the configuration port.
module wav_header_and_sample_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        result_kind_o,
  output logic [2:0]        error_code_o,
  output logic [15:0]       channel_count_o,
  output logic [31:0]       sample_rate_o,
  output logic [15:0]       bits_per_sample_o,
  output logic [31:0]       sample_total_o,
  output logic [15:0]       channel_index_o,
  output logic signed [31:0] sample_value_o
);
  import wsp_pkg::*;

  logic     mode_q;
  logic     accept;
  wsp_cmd_t cmd;
  wsp_sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      mode_q <= pwdata[0];
    end
  end

  assign in_stall_o = out_valid_o && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  wsp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  wsp_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .data_byte_i       (data_byte_i),
    .mid_side_i        (mode_q),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .result_kind_o     (result_kind_o),
    .error_code_o      (error_code_o),
    .channel_count_o   (channel_count_o),
    .sample_rate_o     (sample_rate_o),
    .bits_per_sample_o (bits_per_sample_o),
    .sample_total_o    (sample_total_o),
    .channel_index_o   (channel_index_o),
    .sample_value_o    (sample_value_o)
  );

endmodule

// ===== test/tb_wav_header_and_sample_parser.sv =====
// self-checking testbench for the wave header and sample parser
`timescale 1ns / 1ps

module tb_wav_header_and_sample_parser;
  import wsp_pkg::*;

  localparam logic [2:0] ADDR_MID_SIDE = 3'd0;

  typedef enum logic [2:0] {
    PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_FMT,
    PH_SCAN, PH_DATA_SIZE, PH_SAMPLES, PH_HALTED
  } parse_phase_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  err;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] total;
    logic [15:0] chan_idx;
    logic [31:0] value;
  } parser_result_t;

  typedef struct packed {
    logic [7:0]  stream_byte;
    logic        typed;
    logic [31:0] want;
  } lead_row_t;

  // all-zero run aligns for every depth, then sign extremes
  localparam lead_row_t LEAD_ROWS [24] = '{
    '{8'h00, 1'b1, 32'h0000_0000}, '{8'h00, 1'b1, 32'h0000_0000},
    '{8'h00, 1'b1, 32'h0000_0000}, '{8'h00, 1'b1, 32'h0000_0000},
    '{8'h00, 1'b1, 32'h0000_0000}, '{8'h00, 1'b1, 32'h0000_0000},
    '{8'h00, 1'b1, 32'h0000_0000}, '{8'h00, 1'b1, 32'h0000_0000},
    '{8'h00, 1'b1, 32'h0000_0000}, '{8'h00, 1'b1, 32'h0000_0000},
    '{8'h00, 1'b1, 32'h0000_0000}, '{8'h00, 1'b1, 32'h0000_0000},
    '{8'h00, 1'b0, 32'h0}, '{8'h00, 1'b0, 32'h0},
    '{8'h00, 1'b0, 32'h0}, '{8'h80, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 32'h0}, '{8'hFF, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 32'h0}, '{8'h7F, 1'b0, 32'h0},
    '{8'h01, 1'b0, 32'h0}, '{8'hFE, 1'b0, 32'h0},
    '{8'h80, 1'b0, 32'h0}, '{8'h7F, 1'b0, 32'h0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [2:0]  error_code_o;
  logic [15:0] channel_count_o;
  logic [31:0] sample_rate_o;
  logic [15:0] bits_per_sample_o;
  logic [31:0] sample_total_o;
  logic [15:0] channel_index_o;
  logic signed [31:0] sample_value_o;

  wav_header_and_sample_parser uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .result_kind_o(result_kind_o), .error_code_o(error_code_o),
    .channel_count_o(channel_count_o), .sample_rate_o(sample_rate_o),
    .bits_per_sample_o(bits_per_sample_o), .sample_total_o(sample_total_o),
    .channel_index_o(channel_index_o), .sample_value_o(sample_value_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  parser_result_t due_results [$];
  logic [7:0]     header_bytes [$];
  int             mismatches = 0;
  bit             quiet = 1'b0;
  int             stall_left = 0;

  logic         mid_side = 1'b0;
  parse_phase_e phase = PH_RIFF_TAG;
  logic [31:0]  offset = '0;
  logic [31:0]  riff_left = '0;
  logic [15:0]  chans = '0;
  logic [31:0]  rate = '0;
  logic [15:0]  depth = '0;
  logic [31:0]  shreg = '0;
  logic [7:0]   pair_first = '0;
  logic         saw_da = 1'b0;
  logic [1:0]   byte_cnt = '0;
  logic [15:0]  chan = '0;
  logic [31:0]  left = '0;

  function automatic logic [31:0] wrap_to(input logic [31:0] v, input int w);
    logic [31:0] m;
    if (w >= 32) return v;
    m = 32'd1 << (w - 1);
    v = v & ((m << 1) - 32'd1);
    return (v ^ m) - m;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output parser_result_t r);
    logic [31:0] off;
    logic [31:0] nb;
    logic [31:0] v;
    logic [2:0]  fault;
    r = '0;
    fault = ERR_OK;
    if (phase == PH_HALTED) return 0;
    shreg = {b, shreg[31:8]};
    if (phase < PH_SCAN) begin
      off = offset;
      offset = offset + 32'd1;
      case (off)
        3: begin
          if (shreg != TAG_RIFF) fault = ERR_NOT_RIFF;
          else phase = PH_RIFF_SIZE;
        end
        7: begin
          riff_left = shreg - SIZE_BIAS;
          phase = PH_WAVE_TAG;
        end
        11: begin
          if (shreg != TAG_WAVE) fault = ERR_NOT_WAVE;
          else phase = PH_FMT;
        end
        15: if (shreg != TAG_FMT) fault = ERR_NO_FMT;
        21: if (shreg[31:16] != 16'd1) fault = ERR_FORMAT;
        23: chans = shreg[31:16];
        27: rate = shreg;
        35: begin
          depth = shreg[31:16];
          if (depth != 16'd8 && depth != 16'd16 && depth != 16'd24 && depth != 16'd32) begin
            fault = ERR_FORMAT;
          end else begin
            phase = PH_SCAN;
            saw_da = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (phase == PH_SCAN) begin
      off = offset - SIZE_BIAS;
      offset = offset + 32'd1;
      if (!off[0]) begin
        pair_first = b;
        return 0;
      end
      off = off + 32'd1;
      if (saw_da) begin
        saw_da = 1'b0;
        if (pair_first == CHAR_T && b == CHAR_A) begin
          phase = PH_DATA_SIZE;
          byte_cnt = '0;
          return 0;
        end
      end else if (pair_first == CHAR_D && b == CHAR_A) begin
        saw_da = 1'b1;
        return 0;
      end
      if (off >= riff_left) fault = ERR_NO_DATA;
    end else begin
      nb = {29'd0, depth[5:3]};
      if (nb == 0 || nb > 4) nb = 4;
      if (phase == PH_DATA_SIZE) begin
        if (byte_cnt < 2'd3) begin
          byte_cnt = byte_cnt + 2'd1;
          return 0;
        end
        byte_cnt = '0;
        phase = PH_SAMPLES;
        chan = '0;
        r.kind = KIND_HEADER;
        r.chans = chans;
        r.rate = rate;
        r.bits = depth;
        r.total = shreg / nb;
        return 1;
      end
      if ({30'd0, byte_cnt} + 32'd1 < nb) begin
        byte_cnt = byte_cnt + 2'd1;
        return 0;
      end
      byte_cnt = '0;
      v = wrap_to(shreg >> (32 - 8 * nb), 8 * nb);
      r.kind = KIND_SAMPLE;
      if (mid_side) begin
        if (chan == 16'd0) begin
          left = v;
          r.value = v;
          chan = 16'd1;
        end else begin
          r.chan_idx = 16'd1;
          r.value = wrap_to(left - v, 8 * nb);
          chan = 16'd0;
        end
      end else begin
        r.chan_idx = chan;
        r.value = v;
        if ({16'd0, chan} + 32'd1 >= {16'd0, chans}) chan = '0;
        else chan = chan + 16'd1;
      end
      return 1;
    end
    if (fault != ERR_OK) begin
      phase = PH_HALTED;
      r.kind = KIND_ERROR;
      r.err = fault;
      return 1;
    end
    return 0;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    parser_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: result kind expected none actual %0d", $time, result_kind_o);
        mismatches++;
      end else begin
        exp_r = due_results.pop_front();
        check_field("result_kind", {30'd0, exp_r.kind}, {30'd0, result_kind_o});
        check_field("error_code", {29'd0, exp_r.err}, {29'd0, error_code_o});
        check_field("channel_count", {16'd0, exp_r.chans}, {16'd0, channel_count_o});
        check_field("sample_rate", exp_r.rate, sample_rate_o);
        check_field("bits_per_sample", {16'd0, exp_r.bits}, {16'd0, bits_per_sample_o});
        check_field("sample_total", exp_r.total, sample_total_o);
        check_field("channel_index", {16'd0, exp_r.chan_idx}, {16'd0, channel_index_o});
        check_field("sample_value", exp_r.value, sample_value_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= int'($urandom_range(0, 4));
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic typed, input logic [31:0] want);
    parser_result_t r;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (parse_byte(b, r)) begin
      if (typed && r.kind == KIND_SAMPLE) r.value = want;
      due_results.push_back(r);
    end
  endtask

  task automatic settle(input int tail);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MID_SIDE;
    pwdata <= {31'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mid_side = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("prdata", {31'd0, v}, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) header_bytes.push_back(v[8*i +: 8]);
  endfunction

  task automatic send_header();
    int          fault_pick;
    logic [31:0] riff_size;
    logic [31:0] data_size;
    logic [15:0] ch_field;
    logic [15:0] depth_field;
    fault_pick = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 6)) : 0;
    case ($urandom_range(0, 3))
      0: riff_size = $urandom_range(0, 35);
      1: riff_size = 32'hFFFF_FFFF;
      default: riff_size = SIZE_BIAS + 32'd200 + $urandom_range(0, 100000);
    endcase
    if (fault_pick == 6) riff_size = SIZE_BIAS + 2 * $urandom_range(0, 3);
    case ($urandom_range(0, 5))
      0: ch_field = 16'd0;
      1: ch_field = 16'd1;
      2: ch_field = 16'd2;
      3: ch_field = 16'hFFFF;
      default: ch_field = 16'($urandom_range(3, 8));
    endcase
    depth_field = 16'd8 * 16'($urandom_range(1, 4));
    if (fault_pick == 5) depth_field = 16'($urandom_range(0, 65535)) | 16'd1;
    case ($urandom_range(0, 3))
      0: data_size = 32'd0;
      1: data_size = 32'hFFFF_FFFF;
      default: data_size = $urandom;
    endcase
    header_bytes.delete();
    put_le(fault_pick == 1 ? TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)) : TAG_RIFF, 4);
    put_le(riff_size, 4);
    put_le(fault_pick == 2 ? TAG_WAVE ^ (32'd1 << $urandom_range(0, 31)) : TAG_WAVE, 4);
    put_le(fault_pick == 3 ? TAG_FMT ^ (32'd1 << $urandom_range(0, 31)) : TAG_FMT, 4);
    put_le($urandom, 4);
    put_le(fault_pick == 4 ? 32'd1 ^ (32'd1 << $urandom_range(0, 15)) : 32'd1, 2);
    put_le({16'd0, ch_field}, 2);
    put_le($urandom, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le({16'd0, depth_field}, 2);
    repeat (2 * $urandom_range(0, 4)) header_bytes.push_back(8'($urandom_range(0, 255)));
    // da then da, stray ta, misaligned data tag, then the real one
    put_le({CHAR_A, CHAR_D, CHAR_A, CHAR_D}, 4);
    put_le({16'd0, CHAR_A, CHAR_T}, 2);
    header_bytes.push_back(8'($urandom_range(0, 255)));
    put_le({CHAR_A, CHAR_T, CHAR_A, CHAR_D}, 4);
    header_bytes.push_back(8'($urandom_range(0, 255)));
    put_le({CHAR_A, CHAR_T, CHAR_A, CHAR_D}, 4);
    put_le(data_size, 4);
    foreach (header_bytes[i]) send_byte(header_bytes[i], 1'b0, '0);
  endtask

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [7:0] b;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mode(1'b0);
    send_header();
    foreach (LEAD_ROWS[i]) begin
      send_byte(LEAD_ROWS[i].stream_byte, LEAD_ROWS[i].typed, LEAD_ROWS[i].want);
    end
    for (int round = 0; round < 4; round++) begin
      settle(4);
      write_mode(round % 2 == 0);
      if (round == 3) quiet = 1'b1;
      repeat (240) begin
        case ($urandom_range(0, 7))
          0: b = 8'h00;
          1: b = 8'hFF;
          2: b = 8'h7F;
          3: b = 8'h80;
          default: b = 8'($urandom_range(0, 255));
        endcase
        send_byte(b, 1'b0, '0);
      end
    end
    settle(8);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
